// File: rtl/lae_pkg.sv
// Shared types and constants for the linear ADSR envelope unit.
`default_nettype none

package lae_pkg;

    localparam int COUNT_BITS_DEF    = 24;
    localparam int ACC_FRAC_BITS_DEF = 30;

    localparam int GAIN_W     = 17;
    localparam int MS_W       = 16;
    localparam int RATE_W     = 18;
    localparam int DIV_W      = MS_W + RATE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int MS_PER_S   = 1000;

    localparam logic [GAIN_W-1:0] Q16_ONE = GAIN_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_MS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd4;

    localparam logic [MS_W-1:0]   RST_ATTACK_MS  = 16'd10;
    localparam logic [MS_W-1:0]   RST_DECAY_MS   = 16'd100;
    localparam logic [MS_W-1:0]   RST_RELEASE_MS = 16'd200;
    localparam logic [GAIN_W-1:0] RST_SUSTAIN    = 17'd49152;
    localparam logic [RATE_W-1:0] RST_RATE       = 18'd48000;

    localparam logic [1:0] OP_ATTACK  = 2'd0;
    localparam logic [1:0] OP_DECAY   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef struct packed {
        logic       capture;
        logic       load_mul;
        logic       scale;
        logic       div_run;
        logic       cnt_end;
        logic       step_end;
        logic       apply;
        logic [1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/lae_ctrl.sv
// Sequencing controller for the envelope unit: handshakes and division order.
`default_nettype none

module lae_ctrl
    import lae_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_note_on,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_CNT_END,
        S_DIV,
        S_STEP_END,
        S_APPLY
    } t_state;

    t_state     r_state;
    logic [1:0] r_op;
    logic       r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load_mul = (r_state == S_MUL);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.div_run  = (r_state == S_DIV);
        o_cmd.cnt_end  = (r_state == S_CNT_END);
        o_cmd.step_end = (r_state == S_STEP_END);
        o_cmd.apply    = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);
        o_cmd.op       = r_op;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ATTACK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= i_note_on ? S_MUL : S_APPLY;
                        r_op    <= OP_ATTACK;
                    end
                end
                S_MUL: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_CNT_END;
                end
                S_CNT_END: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= S_STEP_END;
                    end
                end
                S_STEP_END: begin
                    if (r_op == OP_RELEASE) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_op    <= r_op + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_APPLY: begin
                    if (o_cmd.apply) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op != 2'd3)
        else $error("division op index out of range");

    a_apply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites an untaken transaction");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_in_ready && !o_cmd.apply)
        else $error("accept or apply during division");

endmodule

`default_nettype wire

// File: rtl/lae_datapath.sv
// Envelope datapath: configuration, ms-to-sample scaling, step divider, ramp state.
`default_nettype none

module lae_datapath
    import lae_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_note_on,
    input  wire logic                  i_release_on,
    input  wire logic                  i_release_off,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic [GAIN_W-1:0]          o_gain,
    output logic [2:0]                 o_phase,
    output logic                       o_release_pending
);

    localparam int ACC_W = ACC_FRAC_BITS + 1;
    localparam logic [ACC_W-1:0]      ACC_ONE   = ACC_W'(1) << ACC_FRAC_BITS;
    localparam logic [DIV_W-1:0]      CNT_MAX   = DIV_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

    // divide by 1000 as (p >> 3) / 125, the latter by reciprocal multiply
    localparam int          PRE_SHIFT   = 3;
    localparam int          SCALED_W    = DIV_W - PRE_SHIFT;
    localparam int          RECIP_SHIFT = 38;
    localparam int          RECIP_PROD_W = 63;
    localparam logic [31:0] RECIP_125   = 32'd2199023256;

    function automatic logic [GAIN_W-1:0] to_gain(input logic [ACC_W-1:0] a);
        logic [GAIN_W-1:0] g;
        g = a[ACC_FRAC_BITS -: GAIN_W];
        return (g > Q16_ONE) ? Q16_ONE : g;
    endfunction

    logic [MS_W-1:0]   r_attack_ms;
    logic [MS_W-1:0]   r_decay_ms;
    logic [MS_W-1:0]   r_release_ms;
    logic [GAIN_W-1:0] r_sustain;
    logic [RATE_W-1:0] r_rate;

    logic r_note;
    logic r_rel_on;
    logic r_rel_off;

    logic [DIV_W-1:0]      r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_dvsr;
    logic [DIV_CNT_W-1:0]  r_itr;

    t_phase                r_phase;
    logic [ACC_W-1:0]      r_level;
    logic [COUNT_BITS-1:0] r_seg;
    logic [COUNT_BITS-1:0] r_decay_saved;
    logic [COUNT_BITS-1:0] r_release_saved;
    logic [ACC_W-1:0]      r_step [3];
    logic                  r_flag;

    logic [GAIN_W-1:0] r_out_gain;
    t_phase            r_out_phase;
    logic              r_out_flag;

    logic [MS_W-1:0]         w_ms;
    logic [DIV_W-1:0]        w_prod;
    logic [RECIP_PROD_W-1:0] w_recip_prod;
    logic [COUNT_BITS:0]     w_trial;
    logic                    w_ge;
    logic [COUNT_BITS-1:0]   w_cnt;
    logic [GAIN_W-1:0]       w_sus_q16;
    logic [ACC_W-1:0]        w_sus_acc;
    logic [DIV_W-1:0]        w_step_dvd;

    t_phase                w_eff_phase;
    logic [ACC_W-1:0]      w_eff_level;
    logic                  w_eff_flag;
    logic                  w_seg_last;
    t_phase                n_phase;
    logic [ACC_W-1:0]      n_level;
    logic [COUNT_BITS-1:0] n_seg;
    logic                  n_flag;
    logic [GAIN_W-1:0]     n_gain;

    always_comb begin
        case (i_cmd.op)
            OP_ATTACK: w_ms = r_attack_ms;
            OP_DECAY:  w_ms = r_decay_ms;
            default:   w_ms = r_release_ms;
        endcase
    end

    assign w_prod       = DIV_W'(w_ms) * DIV_W'(r_rate);
    assign w_recip_prod = RECIP_PROD_W'(r_quo[DIV_W-1:PRE_SHIFT])
                        * RECIP_PROD_W'(RECIP_125);
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvsr});
    assign o_stat.div_last = (r_itr == DIV_CNT_W'(DIV_W - 1));

    always_comb begin
        if (r_quo > CNT_MAX) begin
            w_cnt = CNT_MAX[COUNT_BITS-1:0];
        end else if (r_quo == '0) begin
            w_cnt = CNT_ONE;
        end else begin
            w_cnt = r_quo[COUNT_BITS-1:0];
        end
    end

    assign w_sus_q16 = (r_sustain > Q16_ONE) ? Q16_ONE : r_sustain;
    assign w_sus_acc = ACC_W'(w_sus_q16) << (ACC_FRAC_BITS - 16);

    always_comb begin
        case (i_cmd.op)
            OP_ATTACK: w_step_dvd = DIV_W'(ACC_ONE);
            OP_DECAY:  w_step_dvd = DIV_W'(ACC_ONE - w_sus_acc);
            default:   w_step_dvd = DIV_W'(w_sus_acc);
        endcase
    end

    assign w_eff_phase = r_note ? PH_ATTACK : r_phase;
    assign w_eff_level = r_note ? '0 : r_level;
    assign w_eff_flag  = r_rel_on | (~r_rel_off & r_flag);
    assign w_seg_last  = (r_seg <= CNT_ONE);

    always_comb begin
        n_phase = w_eff_phase;
        n_level = w_eff_level;
        n_seg   = r_seg;
        n_flag  = w_eff_flag;
        n_gain  = '0;
        case (w_eff_phase)
            PH_ATTACK: begin
                n_gain = to_gain(w_eff_level);
                if (w_seg_last) begin
                    n_phase = PH_DECAY;
                    n_level = ACC_ONE;
                    n_seg   = r_decay_saved;
                end else begin
                    n_level = ACC_W'(w_eff_level + r_step[0]);
                    n_seg   = r_seg - CNT_ONE;
                end
            end
            PH_DECAY: begin
                n_gain  = to_gain(w_eff_level);
                n_level = (w_eff_level >= r_step[1]) ? w_eff_level - r_step[1] : '0;
                if (w_seg_last) begin
                    n_phase = PH_SUSTAIN;
                    n_seg   = '0;
                end else begin
                    n_seg = r_seg - CNT_ONE;
                end
            end
            PH_SUSTAIN: begin
                n_gain = w_sus_q16;
                if (w_eff_flag) begin
                    n_phase = PH_RELEASE;
                    n_level = w_sus_acc;
                    n_seg   = r_release_saved;
                end
            end
            PH_RELEASE: begin
                n_gain  = to_gain(w_eff_level);
                n_level = (w_eff_level >= r_step[2]) ? w_eff_level - r_step[2] : '0;
                if (w_seg_last) begin
                    n_phase = PH_IDLE;
                    n_level = '0;
                    n_seg   = '0;
                    n_flag  = 1'b0;
                end else begin
                    n_seg = r_seg - CNT_ONE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_gain  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_ms  <= RST_ATTACK_MS;
            r_decay_ms   <= RST_DECAY_MS;
            r_release_ms <= RST_RELEASE_MS;
            r_sustain    <= RST_SUSTAIN;
            r_rate       <= RST_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTACK_MS:  r_attack_ms  <= i_cfg_data[MS_W-1:0];
                CFG_DECAY_MS:   r_decay_ms   <= i_cfg_data[MS_W-1:0];
                CFG_RELEASE_MS: r_release_ms <= i_cfg_data[MS_W-1:0];
                CFG_SUSTAIN:    r_sustain    <= i_cfg_data[GAIN_W-1:0];
                CFG_RATE:       r_rate       <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_note    <= i_note_on;
            r_rel_on  <= i_release_on;
            r_rel_off <= i_release_off;
        end
        if (i_cmd.load_mul) begin
            r_quo <= w_prod;
        end else if (i_cmd.scale) begin
            r_quo <= DIV_W'(w_recip_prod[RECIP_PROD_W-1:RECIP_SHIFT]);
        end else if (i_cmd.cnt_end) begin
            r_quo  <= w_step_dvd;
            r_rem  <= '0;
            r_dvsr <= w_cnt;
            r_itr  <= '0;
        end else if (i_cmd.div_run) begin
            r_rem <= w_ge ? COUNT_BITS'(w_trial - {1'b0, r_dvsr})
                          : w_trial[COUNT_BITS-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_itr <= r_itr + DIV_CNT_W'(1);
        end
        if (i_cmd.apply) begin
            r_out_gain  <= n_gain;
            r_out_phase <= n_phase;
            r_out_flag  <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_level         <= '0;
            r_seg           <= '0;
            r_decay_saved   <= '0;
            r_release_saved <= '0;
            r_step[0]       <= '0;
            r_step[1]       <= '0;
            r_step[2]       <= '0;
            r_flag          <= 1'b0;
        end else begin
            if (i_cmd.cnt_end) begin
                case (i_cmd.op)
                    OP_ATTACK: r_seg           <= w_cnt;
                    OP_DECAY:  r_decay_saved   <= w_cnt;
                    default:   r_release_saved <= w_cnt;
                endcase
            end
            if (i_cmd.step_end) begin
                case (i_cmd.op)
                    OP_ATTACK: r_step[0] <= r_quo[ACC_W-1:0];
                    OP_DECAY:  r_step[1] <= r_quo[ACC_W-1:0];
                    default:   r_step[2] <= r_quo[ACC_W-1:0];
                endcase
            end
            if (i_cmd.apply) begin
                r_phase <= n_phase;
                r_level <= n_level;
                r_seg   <= n_seg;
                r_flag  <= n_flag;
            end
        end
    end

    assign o_gain            = r_out_gain;
    assign o_phase           = r_out_phase;
    assign o_release_pending = r_out_flag;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ACC_ONE)
        else $error("level above unity");

    a_seg_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ATTACK || r_phase == PH_DECAY || r_phase == PH_RELEASE)
            |-> r_seg != '0)
        else $error("ramp phase with empty segment count");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_level == '0))
        else $error("idle with non-zero level");

endmodule

`default_nettype wire

// File: rtl/linear_adsr_envelope_unit.sv
// Linear ADSR envelope unit: top level joining controller and datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per audio
//   sample: note_on, release_on, release_off. Output channel (o_out_valid /
//   i_out_ready) returns one transaction per input: gain (Q1.16), phase and
//   release_pending.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//   write only while no transaction is in flight.
//   Without note_on, an accepted sample goes straight to the apply state,
//   where the result is registered once the output register is free.
//   With note_on, each of the three segments takes a registered ms x rate
//   multiply, a reciprocal multiply for the division by 1000 and one pass of
//   a shared radix-2 divider of 34 iterations for the ramp step, in the
//   order attack, decay, release, before the result is registered.
//   One transaction is in flight at a time; the next input is taken in the
//   cycle after the result is registered, even if that result is not taken.
//   Receiver stall: the result register holds; a further result waits until
//   it is taken, and input acceptance stops meanwhile.
//   Reset (synchronous, active low): envelope idle, level zero, release flag
//   clear, configuration at its default values.
`default_nettype none

module linear_adsr_envelope_unit
    import lae_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_note_on,
    input  wire logic                  i_release_on,
    input  wire logic                  i_release_off,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [GAIN_W-1:0]          o_gain,
    output logic [2:0]                 o_phase,
    output logic                       o_release_pending
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_note_on   (i_note_on),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    lae_datapath #(
        .COUNT_BITS    (COUNT_BITS),
        .ACC_FRAC_BITS (ACC_FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_note_on         (i_note_on),
        .i_release_on      (i_release_on),
        .i_release_off     (i_release_off),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_gain            (o_gain),
        .o_phase           (o_phase),
        .o_release_pending (o_release_pending)
    );

endmodule

`default_nettype wire

// File: bench/tb_linear_adsr_envelope_unit.sv
// Self-checking testbench for the linear ADSR envelope unit.
`default_nettype none

module tb_linear_adsr_envelope_unit;
    import lae_pkg::*;

    localparam logic [63:0] CNT_LIMIT = (64'd1 << COUNT_BITS_DEF) - 64'd1;
    localparam logic [63:0] ACC_UNIT  = 64'd1 << ACC_FRAC_BITS_DEF;
    localparam int          Q_SHIFT   = ACC_FRAC_BITS_DEF - 16;
    localparam int          SETTLE    = 8;

    typedef struct packed {
        logic note_on;
        logic release_on;
        logic release_off;
    } sample_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        t_phase            phase;
        logic              pending;
    } env_sample_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_note_on = 1'b0;
    logic                  i_release_on = 1'b0;
    logic                  i_release_off = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [GAIN_W-1:0]     o_gain;
    logic [2:0]            o_phase;
    logic                  o_release_pending;

    sample_req_t pending_samples[$];
    env_sample_t expected_samples[$];

    int in_idle_pct   = 24;
    int out_stall_pct = 24;
    int n_errors      = 0;
    int n_samples     = 0;
    int n_queued      = 0;
    int n_notes       = 0;
    int n_release_end = 0;
    int n_settings    = 0;

    // shadow of the configuration registers
    logic [63:0] cfg_attack_ms  = 64'(RST_ATTACK_MS);
    logic [63:0] cfg_decay_ms   = 64'(RST_DECAY_MS);
    logic [63:0] cfg_release_ms = 64'(RST_RELEASE_MS);
    logic [63:0] cfg_sustain    = 64'(RST_SUSTAIN);
    logic [63:0] cfg_rate       = 64'(RST_RATE);

    // envelope state
    t_phase      env_phase   = PH_IDLE;
    logic [63:0] env_level   = '0;
    logic [63:0] env_count   = '0;
    logic [63:0] decay_len   = '0;
    logic [63:0] release_len = '0;
    logic [63:0] atk_step    = '0;
    logic [63:0] dec_step    = '0;
    logic [63:0] rel_step    = '0;
    logic        rel_flag    = 1'b0;

    linear_adsr_envelope_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_note_on         (i_note_on),
        .i_release_on      (i_release_on),
        .i_release_off     (i_release_off),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_gain            (o_gain),
        .o_phase           (o_phase),
        .o_release_pending (o_release_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] segment_len(input logic [63:0] ms);
        logic [63:0] n;
        n = (ms * cfg_rate) / 64'(MS_PER_S);
        if (n > CNT_LIMIT) n = CNT_LIMIT;
        if (n == 64'd0) n = 64'd1;
        return n;
    endfunction

    function automatic logic [63:0] sustain_q16();
        return (cfg_sustain > 64'(Q16_ONE)) ? 64'(Q16_ONE) : cfg_sustain;
    endfunction

    function automatic logic [63:0] level_to_gain(input logic [63:0] acc);
        logic [63:0] g;
        g = acc >> Q_SHIFT;
        return (g > 64'(Q16_ONE)) ? 64'(Q16_ONE) : g;
    endfunction

    task automatic predict_sample(input logic note, input logic r_on, input logic r_off);
        env_sample_t want;
        logic [63:0] sus;
        logic [63:0] na;
        logic [63:0] g;
        sus = sustain_q16() << Q_SHIFT;
        g = 64'd0;
        if (note) begin
            na          = segment_len(cfg_attack_ms);
            decay_len   = segment_len(cfg_decay_ms);
            release_len = segment_len(cfg_release_ms);
            atk_step    = ACC_UNIT / na;
            dec_step    = (ACC_UNIT - sus) / decay_len;
            rel_step    = sus / release_len;
            env_count   = na;
            env_level   = 64'd0;
            env_phase   = PH_ATTACK;
            n_notes++;
        end
        if (r_on) rel_flag = 1'b1;
        else if (r_off) rel_flag = 1'b0;
        case (env_phase)
            PH_ATTACK: begin
                g = level_to_gain(env_level);
                env_level += atk_step;
                if (env_count <= 64'd1) begin
                    env_phase = PH_DECAY;
                    env_level = ACC_UNIT;
                    env_count = decay_len;
                end else begin
                    env_count--;
                end
            end
            PH_DECAY: begin
                g = level_to_gain(env_level);
                env_level = (env_level >= dec_step) ? env_level - dec_step : 64'd0;
                if (env_count <= 64'd1) begin
                    env_phase = PH_SUSTAIN;
                    env_count = 64'd0;
                end else begin
                    env_count--;
                end
            end
            PH_SUSTAIN: begin
                g = sustain_q16();
                if (rel_flag) begin
                    env_phase = PH_RELEASE;
                    env_level = sus;
                    env_count = release_len;
                end
            end
            PH_RELEASE: begin
                g = level_to_gain(env_level);
                env_level = (env_level >= rel_step) ? env_level - rel_step : 64'd0;
                if (env_count <= 64'd1) begin
                    env_phase = PH_IDLE;
                    env_level = 64'd0;
                    env_count = 64'd0;
                    rel_flag  = 1'b0;
                    n_release_end++;
                end else begin
                    env_count--;
                end
            end
            default: begin
                env_phase = PH_IDLE;
            end
        endcase
        want.gain    = g[GAIN_W-1:0];
        want.phase   = env_phase;
        want.pending = rel_flag;
        expected_samples.push_back(want);
        n_samples++;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : driver
        logic        free;
        sample_req_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            free = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_sample(i_note_on, i_release_on, i_release_off);
                free = 1'b1;
            end
            if (free) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    nxt = pending_samples.pop_front();
                    i_in_valid    <= 1'b1;
                    i_note_on     <= nxt.note_on;
                    i_release_on  <= nxt.release_on;
                    i_release_off <= nxt.release_off;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        env_sample_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected transaction, gain", o_gain, 0);
                end else begin
                    want = expected_samples.pop_front();
                    if (o_gain !== want.gain)
                        report_mismatch("gain", o_gain, want.gain);
                    if (o_phase !== want.phase)
                        report_mismatch("phase", o_phase, want.phase);
                    if (o_release_pending !== want.pending)
                        report_mismatch("release_pending", o_release_pending, want.pending);
                end
            end
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic queue_item(input logic note, input logic r_on, input logic r_off);
        sample_req_t req;
        req.note_on     = note;
        req.release_on  = r_on;
        req.release_off = r_off;
        pending_samples.push_back(req);
        n_queued++;
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_samples.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic load_settings(input logic [MS_W-1:0] atk, input logic [MS_W-1:0] dec,
                                 input logic [MS_W-1:0] rel, input logic [GAIN_W-1:0] sus,
                                 input logic [RATE_W-1:0] rate);
        put_reg(CFG_ATTACK_MS, CFG_DATA_W'(atk));
        put_reg(CFG_DECAY_MS, CFG_DATA_W'(dec));
        put_reg(CFG_RELEASE_MS, CFG_DATA_W'(rel));
        put_reg(CFG_SUSTAIN, CFG_DATA_W'(sus));
        put_reg(CFG_RATE, CFG_DATA_W'(rate));
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        cfg_attack_ms  = 64'(atk);
        cfg_decay_ms   = 64'(dec);
        cfg_release_ms = 64'(rel);
        cfg_sustain    = 64'(sus);
        cfg_rate       = 64'(rate);
        n_settings++;
    endtask

    // well-formed notes with random lengths, plus some noise
    task automatic queue_notes(input int budget);
        int          start;
        int          hold;
        int          tail;
        logic [63:0] span_ad;
        logic [63:0] span_r;
        start = n_queued;
        while (n_queued - start < budget) begin
            if ($urandom_range(99) < 80) begin
                span_ad = segment_len(cfg_attack_ms) + segment_len(cfg_decay_ms);
                if (span_ad > 64'd60) span_ad = 64'd60;
                span_r = segment_len(cfg_release_ms);
                if (span_r > 64'd60) span_r = 64'd60;
                queue_item(1'b1, $urandom_range(99) < 10, 1'b0);
                hold = $urandom_range(0, int'(span_ad) + 4);
                repeat (hold) queue_item(1'b0, 1'b0, $urandom_range(99) < 10);
                queue_item(1'b0, 1'b1, 1'($urandom_range(1)));
                tail = $urandom_range(0, int'(span_r) + 3);
                repeat (tail) queue_item(1'b0, $urandom_range(99) < 5, $urandom_range(99) < 10);
            end else begin
                queue_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        logic [31:0]       r0;
        logic [31:0]       r1;
        logic [31:0]       r2;
        logic [31:0]       r3;
        logic [31:0]       r4;
        logic [GAIN_W-1:0] sus;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: flag handling while idle, then a long attack
        queue_item(1'b0, 1'b1, 1'b1);
        queue_item(1'b0, 1'b0, 1'b1);
        queue_item(1'b1, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        wait_quiet();

        // one-sample attack and decay, sustain clamped, short release to idle
        load_settings(16'd0, 16'd1, 16'd2, 17'h1FFFF, 18'd1000);
        queue_item(1'b1, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b0, 1'b1, 1'b1);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        wait_quiet();

        // zero rate and zero sustain; release to idle, then a restart with release_on
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd0, 18'd0);
        queue_item(1'b1, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b0, 1'b1, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b1, 1'b1, 1'b0);
        queue_item(1'b0, 1'b0, 1'b0);
        wait_quiet();

        // saturated attack length
        load_settings(16'hFFFF, 16'd0, 16'd1, 17'd65537, 18'h3FFFF);
        queue_item(1'b1, 1'b0, 1'b1);
        queue_item(1'b0, 1'b0, 1'b0);
        queue_item(1'b0, 1'b0, 1'b1);
        wait_quiet();

        for (int p = 0; p < 10; p++) begin
            in_idle_pct   = (p == 7) ? 0 : 24;
            out_stall_pct = (p == 7) ? 0 : 24;
            r0 = $urandom;
            r1 = $urandom;
            r2 = $urandom;
            r3 = $urandom;
            r4 = $urandom;
            case ($urandom_range(9))
                0:       sus = 17'd0;
                1:       sus = Q16_ONE;
                2:       sus = GAIN_W'($urandom_range(65537, 131071));
                default: sus = GAIN_W'($urandom_range(0, 65536));
            endcase
            case (p)
                2: load_settings(16'd0, 16'd0, 16'd0, 17'd0, 18'd1000);
                5: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, Q16_ONE, 18'd192000);
                8: load_settings(r0[15:0], r1[15:0], r2[15:0], r3[16:0], r4[17:0]);
                default: load_settings(MS_W'($urandom_range(0, 12)),
                                       MS_W'($urandom_range(0, 12)),
                                       MS_W'($urandom_range(0, 12)), sus,
                                       RATE_W'($urandom_range(1000, 4000)));
            endcase
            queue_notes(135);
            wait_quiet();
        end

        $display("Covered %0d samples, %0d note starts, %0d completed releases, %0d settings",
                 n_samples, n_notes, n_release_end, n_settings);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: linear_adsr_envelope_unit.f
rtl/lae_pkg.sv
rtl/lae_ctrl.sv
rtl/lae_datapath.sv
rtl/linear_adsr_envelope_unit.sv
bench/tb_linear_adsr_envelope_unit.sv
